// ===== rtl/core/signed_int_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the conversion block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define SIDA_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SIDA_ASSERT_NOW(lbl, clk, rstn, pre, post)
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/core/sida_pkg.sv =====
package sida_pkg;

    localparam int         ValueWidth = 32;
    localparam int         NumDigits  = 10;
    localparam int         BcdWidth   = 4 * NumDigits;
    localparam int         CharWidth  = 6;
    localparam logic [4:0] LastStep   = 5'(ValueWidth - 1);
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_NINE  = 6'd57;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic step;
        logic setup;
        logic push_sign;
        logic push_digit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic conv_done;
        logic neg;
        logic last_digit;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/sida_datapath.sv =====
`include "signed_int_to_decimal_ascii_macros.svh"

module sida_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sida_pkg::t_cmd             i_cmd,
    output sida_pkg::t_status          o_status,
    input  logic [31:0]                i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [5:0]                 o_char,
    output logic                       o_last
);
    import sida_pkg::*;

    logic [ValueWidth-1:0] r_bin, n_bin;
    logic [BcdWidth-1:0]   r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [4:0]            r_cnt, n_cnt;
    logic [3:0]            r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [5:0]            r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;

    logic [BcdWidth-1:0]   adj_bcd;
    logic [3:0]            lead_idx;
    logic [3:0]            cur_digit;
    logic                  out_free;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NumDigits; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Highest non-zero digit; zero itself keeps index zero.
    always_comb begin
        lead_idx = 4'd0;
        for (int i = 0; i < NumDigits; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                lead_idx = 4'(i);
            end
        end
    end

    assign cur_digit = r_bcd[{r_idx, 2'b00} +: 4];
    assign out_free  = !r_out_valid || i_ready;

    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load) begin
            n_neg = i_value[ValueWidth-1];
            n_bin = i_value[ValueWidth-1] ? (32'd0 - i_value) : i_value;
            n_bcd = '0;
            n_cnt = '0;
        end
        if (i_cmd.step) begin
            n_bcd = {adj_bcd[BcdWidth-2:0], r_bin[ValueWidth-1]};
            n_bin = {r_bin[ValueWidth-2:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
        end
        if (i_cmd.setup) begin
            n_idx = lead_idx;
        end
        if (i_cmd.push_sign) begin
            n_out_valid = 1'b1;
            n_out_char  = CHAR_MINUS;
            n_out_last  = 1'b0;
        end
        if (i_cmd.push_digit) begin
            n_out_valid = 1'b1;
            n_out_char  = CHAR_ZERO + {2'b00, cur_digit};
            n_out_last  = (r_idx == 4'd0);
            n_idx       = r_idx - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_status.conv_done  = (r_cnt == LastStep);
    assign o_status.neg        = r_neg;
    assign o_status.last_digit = (r_idx == 4'd0);
    assign o_status.out_free   = out_free;

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    `SIDA_ASSERT_NOW(a_push_free, i_clk, i_rst_n, i_cmd.push_sign || i_cmd.push_digit, out_free)
    `SIDA_ASSERT_NOW(a_digit_bcd, i_clk, i_rst_n, i_cmd.push_digit, cur_digit <= 4'd9)
    `SIDA_ASSERT_NOW(a_char_range, i_clk, i_rst_n, r_out_valid,
        (r_out_char == CHAR_MINUS) || ((r_out_char >= CHAR_ZERO) && (r_out_char <= CHAR_NINE)))
    `SIDA_ASSERT_NEXT(a_sign_first, i_clk, i_rst_n, i_cmd.push_sign, r_out_valid && !r_out_last)

endmodule

// ===== rtl/core/sida_ctrl.sv =====
module sida_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sida_pkg::t_status i_status,
    output sida_pkg::t_cmd    o_cmd
);
    import sida_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_status.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.push_sign = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.push_digit = 1'b1;
                    if (i_status.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Channel    Dir  tdata bits            tuser  tlast
// s_axis     in   [31:0] value          -      -
// m_axis     out  [5:0] character, pad  -      last character of the number
//
// Sequence: one word is taken, then 32 shift-and-add-3 steps of the bit-serial
// binary to BCD loop, a setup step, then 1 to 11 characters, one a cycle while
// m_axis_tready is high.
// Reset: synchronous, active low; clears the controller state and the output valid.
// Stalls: a held m_axis_tready holds the character register and freezes emission.
// A new word is taken as soon as the last character is loaded, even while it waits.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [5:0] character, [7:6] zero
    output logic        o_m_axis_tlast
);
    import sida_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [5:0] out_char;

    // Sequence load, conversion, sign and digits.
    sida_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Magnitude, BCD shift register and the character output register.
    sida_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_value  (i_s_axis_tdata),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_char   (out_char),
        .o_last   (o_m_axis_tlast)
    );

    // Pad the character to a whole byte.
    assign o_m_axis_tdata = {2'b00, out_char};

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sida_pkg::*;

    localparam int ITEMS     = 410;  // words sent in total
    localparam int ROWS      = 21;   // directed words at the head of the run
    localparam int CALM_TAIL = 40;   // closing words sent with neither side idling
    localparam int DRAIN_AT  = 150;  // random word before which the sender waits for all text

    // One expected output word: ASCII code plus end-of-number marker.
    typedef struct packed {
        logic [CharWidth-1:0] code;
        logic                 last;
    } t_char_word;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ValueWidth-1:0] s_tdata  = '0;   // [31:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;         // [5:0] character, [7:6] zero
    logic                  m_tlast;

    t_char_word char_q [$];   // characters still owed by the block, oldest first
    int         mismatches = 0;
    bit         calm       = 1'b0;  // set for the closing stretch: no idling on either side

    // Directed words. An empty text means the characters come from the predictor;
    // otherwise the text is the exact expected output.
    logic [ValueWidth-1:0] row_value [ROWS] = '{
        32'h0000_0000,   // zero
        32'h0000_0001,
        32'hFFFF_FFFF,   // -1
        32'h0000_0009,
        32'h0000_000A,
        32'hFFFF_FFF6,   // -10
        32'h7FFF_FFFF,   // largest positive
        32'h8000_0000,   // most negative, magnitude only fits unsigned
        32'h8000_0001,
        32'h3B9A_CA00,   // 1000000000, ten digits
        32'h3B9A_C9FF,   // 999999999
        32'hC465_3600,   // -1000000000
        32'h0000_0063,   // 99
        32'h0000_0064,   // 100
        32'h0000_3039,   // 12345
        32'hFFFF_FFF7,   // -9
        32'h5555_5555,
        32'hAAAA_AAAA,
        32'h4000_0000,
        32'hBFFF_FFFF,
        32'hFFFE_7960    // -100000
    };
    string row_text [ROWS] = '{
        "0", "1", "-1", "9", "10", "", "2147483647", "-2147483648", "-2147483647",
        "1000000000", "", "", "", "", "", "-9", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Work out the decimal text of one value and queue its characters.
    function automatic void predict_decimal_text(logic [ValueWidth-1:0] value);
        logic                  neg;
        logic [ValueWidth-1:0] mag;
        logic [3:0]            digits [NumDigits];
        int                    n;
        t_char_word            w;
        neg = value[ValueWidth-1];
        // Negate in unsigned arithmetic so the most negative value keeps its magnitude.
        mag = neg ? (ValueWidth'(0) - value) : value;
        n   = 0;
        do begin
            digits[n] = 4'(mag % 10);
            mag       = mag / 10;
            n++;
        end while (mag != 0 && n < NumDigits);
        if (neg) begin
            w.code = CHAR_MINUS;
            w.last = 1'b0;
            char_q.push_back(w);
        end
        for (int k = n - 1; k >= 0; k--) begin
            w.code = CHAR_ZERO + CharWidth'(digits[k]);
            w.last = (k == 0);
            char_q.push_back(w);
        end
    endfunction

    // Queue a literal expected text, marking its final character.
    function automatic void queue_literal_text(string text);
        byte        b;
        t_char_word w;
        for (int i = 0; i < text.len(); i++) begin
            b      = text[i];
            w.code = b[CharWidth-1:0];
            w.last = (i == text.len() - 1);
            char_q.push_back(w);
        end
    endfunction

    // Random value, biased towards digit-count boundaries, small numbers and the limits.
    function automatic logic [ValueWidth-1:0] pick_value();
        logic [ValueWidth-1:0] v;
        logic [ValueWidth-1:0] p;
        int                    sel;
        sel = $urandom_range(0, 7);
        p   = 1;
        case (sel)
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 99);
            4: begin
                // Hug a power of ten: one below, on it, one above.
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
            end
            5:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                              : 32'h8000_0000 + $urandom_range(0, 3);
            6:       v = $urandom_range(0, 99999);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if (sel != 5 && $urandom_range(0, 1) == 1) begin
            v = ValueWidth'(0) - v;
        end
        return v;
    endfunction

    // Offer one word and hold it until the block takes it; then log what it owes.
    task automatic send_word(logic [ValueWidth-1:0] value, string text);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        if (text.len() == 0) begin
            predict_decimal_text(value);
        end else begin
            queue_literal_text(text);
        end
    endtask

    // Drop valid for a random burst, with junk on the data lines.
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end
    endtask

    // Sender: reset, directed rows, then random words.
    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++) begin
            sender_gap();
            send_word(row_value[i], row_text[i]);
        end

        for (int i = 0; i < ITEMS - ROWS; i++) begin
            if (i == ITEMS - ROWS - CALM_TAIL) begin
                calm = 1'b1;
            end
            if (i == DRAIN_AT) begin
                // Hold off until every owed character has come out.
                @(negedge i_clk);
                s_tvalid <= 1'b0;
                while (char_q.size() != 0) @(posedge i_clk);
            end
            sender_gap();
            send_word(pick_value(), "");
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Wait for the text to drain, then keep watching for stray characters.
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatches == 0 && char_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Receiver: stall in random bursts until the closing stretch.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 19) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each accepted character against the oldest owed one.
    always @(posedge i_clk) begin : check_chars
        t_char_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (char_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected character: tdata=%h tlast=%b", m_tdata, m_tlast);
                end
                mismatches++;
            end else begin
                want = char_q.pop_front();
                // Padding bits above the character must read zero as well.
                if (m_tdata !== {{(8 - CharWidth){1'b0}}, want.code} ||
                    m_tlast !== want.last) begin
                    if (mismatches < 10) begin
                        $display("character mismatch: expected code=%0d last=%b,",
                                 want.code, want.last,
                                 " got tdata=%h tlast=%b", m_tdata, m_tlast);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sida_pkg.sv
rtl/core/sida_datapath.sv
rtl/core/sida_ctrl.sv
rtl/core/signed_int_to_decimal_ascii.sv
test/testbench.sv
